// ----- rtl/display_list_line_sequencer_unit_assert.svh -----
// Assertion macros for the display list line sequencer.
`ifndef DISPLAY_LIST_LINE_SEQUENCER_UNIT_ASSERT_SVH
`define DISPLAY_LIST_LINE_SEQUENCER_UNIT_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define DLLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on every clock edge outside reset.
`define DLLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dlls_pkg.sv -----
// ----------------------------------------------------------------------------
// dlls_pkg
// Types, codes and tables shared by the display list line sequencer.
// ----------------------------------------------------------------------------
package dlls_pkg;

  localparam int unsigned VblankLineDef   = 248;
  localparam int unsigned FirstVisibleDef = 8;
  localparam int unsigned VisibleLinesDef = 240;
  localparam int unsigned CyclesPerLineDef = 114;
  localparam int unsigned GuardDef        = 64;

  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_FRAME = 3'd2;
  localparam logic [2:0] ACT_LINE  = 3'd3;
  localparam logic [2:0] ACT_MEM   = 3'd4;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_FETCH = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_INSN = 3'd1;
  localparam logic [2:0] PH_JLO  = 3'd2;
  localparam logic [2:0] PH_JHI  = 3'd3;
  localparam logic [2:0] PH_LLO  = 3'd4;
  localparam logic [2:0] PH_LHI  = 3'd5;

  localparam logic [3:0] REG_DMACTL = 4'h0;
  localparam logic [3:0] REG_CHACTL = 4'h1;
  localparam logic [3:0] REG_DLISTL = 4'h2;
  localparam logic [3:0] REG_DLISTH = 4'h3;
  localparam logic [3:0] REG_HSCROL = 4'h4;
  localparam logic [3:0] REG_VSCROL = 4'h5;
  localparam logic [3:0] REG_PMBASE = 4'h7;
  localparam logic [3:0] REG_CHBASE = 4'h9;
  localparam logic [3:0] REG_WSYNC  = 4'hA;
  localparam logic [3:0] REG_VCOUNT = 4'hB;
  localparam logic [3:0] REG_NMIEN  = 4'hE;
  localparam logic [3:0] REG_NMIST  = 4'hF;

  // Datapath operations chosen by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ,
    OP_FRAME,
    OP_LINE,
    OP_MEM,
    OP_FINISH
  } dlls_op_e;

  typedef struct packed {
    dlls_op_e op;
  } dlls_cmd_t;

  typedef struct packed {
    logic fin_pending;
    logic has_result;
  } dlls_sts_t;

  function automatic logic [4:0] blk_lines(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2, 4'd4, 4'd6, 4'd8: r = 5'd8;
      4'd3:                   r = 5'd10;
      4'd5, 4'd7:             r = 5'd16;
      4'd9, 4'd10:            r = 5'd4;
      4'd11, 4'd13:           r = 5'd2;
      default:                r = 5'd1;
    endcase
    return r;
  endfunction

  // Bytes per row: width / span, width in {0,256,320,384}.
  function automatic logic [15:0] block_bytes(input logic [3:0] m, input logic [1:0] w);
    logic [8:0] wd;
    logic [15:0] r;
    unique case (w)
      2'd0: wd = 9'd0;
      2'd1: wd = 9'd256;
      2'd2: wd = 9'd320;
      default: wd = 9'd384;
    endcase
    unique case (m)
      4'd2, 4'd3, 4'd4, 4'd5, 4'd13, 4'd14, 4'd15: r = {10'd0, wd[8:3]};
      4'd6, 4'd7, 4'd10, 4'd11, 4'd12:             r = {11'd0, wd[8:4]};
      4'd8, 4'd9:                                  r = {12'd0, wd[8:5]};
      default:                                     r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/display_list_line_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// display_list_line_sequencer_unit
// Display list line sequencer: register port, list fetch and line finish.
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// in      | in_valid_i | in_stall_o | action, reg_offset, write_value,
//         |           |           | line_number, mem_byte
// out     | out_valid_o| out_stall_i| result_kind ... screen_address
// An item without a result is taken in the idle state; a read or fetch result
// goes on to the output state, where it may be stalled, and a finished line
// first passes through the finish state. The controller state sets this.
// Reset clears all registers. Input is stalled while a result waits.
module display_list_line_sequencer_unit #(
  parameter int unsigned VBLANK_LINE     = dlls_pkg::VblankLineDef,
  parameter int unsigned FIRST_VISIBLE   = dlls_pkg::FirstVisibleDef,
  parameter int unsigned VISIBLE_LINES   = dlls_pkg::VisibleLinesDef,
  parameter int unsigned CYCLES_PER_LINE = dlls_pkg::CyclesPerLineDef,
  parameter int unsigned GUARD           = dlls_pkg::GuardDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [3:0]  reg_offset_i,
  input  logic [7:0]  write_value_i,
  input  logic [8:0]  line_number_i,
  input  logic [7:0]  mem_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  read_data_o,
  output logic [15:0] fetch_address_o,
  output logic [6:0]  stolen_cycles_o,
  output logic [1:0]  nmi_raised_o,
  output logic [3:0]  line_mode_o,
  output logic [4:0]  block_row_o,
  output logic [15:0] screen_address_o
);
  import dlls_pkg::*;

  dlls_cmd_t cmd;
  dlls_sts_t sts;

  dlls_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .sts_i(sts)
  );

  dlls_datapath #(
    .VBLANK_LINE(VBLANK_LINE), .FIRST_VISIBLE(FIRST_VISIBLE),
    .VISIBLE_LINES(VISIBLE_LINES), .CYCLES_PER_LINE(CYCLES_PER_LINE),
    .GUARD(GUARD)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .reg_offset_i, .write_value_i,
    .line_number_i, .mem_byte_i, .result_kind_o, .read_data_o, .fetch_address_o,
    .stolen_cycles_o, .nmi_raised_o, .line_mode_o, .block_row_o, .screen_address_o
  );

`include "display_list_line_sequencer_unit_assert.svh"

  `DLLS_ASSERT_IMP(a_out_stalls_in, clk_i, rst_ni, out_valid_o, in_stall_o, "input open with result")
  `DLLS_ASSERT_IMP(a_kind_ok, clk_i, rst_ni, out_valid_o, result_kind_o != 2'd3, "bad kind")
  `DLLS_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_kind_o), "result dropped")

endmodule

// ----- rtl/dlls_ctrl.sv -----
// ----------------------------------------------------------------------------
// dlls_ctrl
// Controller: accepts items, sequences datapath operations, drives the output.
// ----------------------------------------------------------------------------
module dlls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          action_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dlls_pkg::dlls_cmd_t cmd_o,
  input  dlls_pkg::dlls_sts_t sts_i
);
  import dlls_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FIN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o.op = OP_NONE;
    if (accept) begin
      unique case (action_i)
        ACT_WRITE: cmd_o.op = OP_WRITE;
        ACT_READ:  cmd_o.op = OP_READ;
        ACT_FRAME: cmd_o.op = OP_FRAME;
        ACT_LINE:  cmd_o.op = OP_LINE;
        ACT_MEM:   cmd_o.op = OP_MEM;
        default:   cmd_o.op = OP_NONE;
      endcase
    end else if (state_q == ST_FIN) begin
      cmd_o.op = OP_FINISH;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.fin_pending) state_d = ST_FIN;
          else if (sts_i.has_result) state_d = ST_OUT;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/dlls_datapath.sv -----
// ----------------------------------------------------------------------------
// dlls_datapath
// Registers, instruction decode and line finish arithmetic.
// ----------------------------------------------------------------------------
module dlls_datapath #(
  parameter int unsigned VBLANK_LINE     = dlls_pkg::VblankLineDef,
  parameter int unsigned FIRST_VISIBLE   = dlls_pkg::FirstVisibleDef,
  parameter int unsigned VISIBLE_LINES   = dlls_pkg::VisibleLinesDef,
  parameter int unsigned CYCLES_PER_LINE = dlls_pkg::CyclesPerLineDef,
  parameter int unsigned GUARD           = dlls_pkg::GuardDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dlls_pkg::dlls_cmd_t cmd_i,
  output dlls_pkg::dlls_sts_t sts_o,
  input  logic [3:0]          reg_offset_i,
  input  logic [7:0]          write_value_i,
  input  logic [8:0]          line_number_i,
  input  logic [7:0]          mem_byte_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          read_data_o,
  output logic [15:0]         fetch_address_o,
  output logic [6:0]          stolen_cycles_o,
  output logic [1:0]          nmi_raised_o,
  output logic [3:0]          line_mode_o,
  output logic [4:0]          block_row_o,
  output logic [15:0]         screen_address_o
);
  import dlls_pkg::*;

  localparam logic [8:0] VblL  = 9'(VBLANK_LINE);
  localparam logic [8:0] FvisL = 9'(FIRST_VISIBLE);
  localparam logic [9:0] LvisL = 10'(FIRST_VISIBLE + VISIBLE_LINES);
  localparam logic [7:0] CapL  = 8'(CYCLES_PER_LINE - 8);
  localparam logic [6:0] GuardL = 7'(GUARD);

  logic [7:0]  dma_q, chctl_q, pmb_q, chb_q, nmien_q, nmist_q;
  logic [3:0]  hsa_q, vsa_q;
  logic [15:0] lst_q, lp_q, scan_q;
  logic [3:0]  mode_q;
  logic [4:0]  row_q, hgt_q;
  logic        dli_q, hson_q, vson_q, fin_q, wsync_q;
  logic [8:0]  vcount_q, pline_q;
  logic [2:0]  ph_q;
  logic [7:0]  instr_q, lo_q;
  logic [6:0]  guard_q;
  logic [7:0]  pst_q;
  logic [1:0]  pnmi_q;

  logic [1:0]  kind_q;
  logic [7:0]  rd_q;
  logic [15:0] fa_q, scr_q;
  logic [6:0]  st_q;
  logic [1:0]  nr_q;
  logic [3:0]  lm_q;
  logic [4:0]  br_q;

  logic [15:0] bb;
  logic [7:0]  stolen_sum;
  logic [4:0]  row_inc;
  logic [6:0]  guard_inc;
  logic [15:0] target;
  logic        need_new, dli_hit;

  assign bb         = block_bytes(mode_q, dma_q[1:0]);
  assign row_inc    = row_q + 5'd1;
  assign guard_inc  = guard_q + 7'd1;
  assign target     = {mem_byte_i, lo_q};
  assign need_new   = (line_number_i < VblL) && (row_q >= hgt_q);
  assign dli_hit    = (pline_q < VblL) && dli_q && (hgt_q != 5'd0) &&
                      (row_q == hgt_q - 5'd1);

  always_comb begin
    stolen_sum = pst_q;
    if ((pline_q >= FvisL) && ({1'b0, pline_q} < LvisL) && (mode_q >= 4'd2)) begin
      stolen_sum = pst_q + ((mode_q <= 4'd7) ? {bb[6:0], 1'b0} : bb[7:0]);
    end
  end

  always_comb begin
    sts_o.fin_pending = 1'b0;
    sts_o.has_result  = 1'b0;
    unique case (cmd_i.op)
      OP_READ: sts_o.has_result = 1'b1;
      OP_LINE: begin
        sts_o.has_result  = 1'b1;
        sts_o.fin_pending = !(need_new && dma_q[5] && !fin_q);
      end
      OP_MEM: begin
        sts_o.has_result = (ph_q != PH_IDLE) && (ph_q <= PH_LHI);
        unique case (ph_q)
          PH_INSN: sts_o.fin_pending = (mem_byte_i[3:0] != 4'd1) &&
                   ((mem_byte_i[3:0] == 4'd0) || !mem_byte_i[6]);
          PH_JHI:  sts_o.fin_pending = instr_q[6] || (guard_inc >= GuardL);
          PH_LHI:  sts_o.fin_pending = 1'b1;
          default: sts_o.fin_pending = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dma_q <= '0; chctl_q <= '0; pmb_q <= '0; chb_q <= '0;
      nmien_q <= '0; nmist_q <= '0; hsa_q <= '0; vsa_q <= '0;
      lst_q <= '0; lp_q <= '0; scan_q <= '0; mode_q <= '0;
      row_q <= '0; hgt_q <= '0; dli_q <= 1'b0; hson_q <= 1'b0;
      vson_q <= 1'b0; fin_q <= 1'b0; wsync_q <= 1'b0;
      vcount_q <= '0; pline_q <= '0; ph_q <= PH_IDLE;
      instr_q <= '0; lo_q <= '0; guard_q <= '0; pst_q <= '0; pnmi_q <= '0;
      kind_q <= KIND_READ; rd_q <= '0; fa_q <= '0; scr_q <= '0;
      st_q <= '0; nr_q <= '0; lm_q <= '0; br_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_WRITE: begin
          unique case (reg_offset_i)
            REG_DMACTL: dma_q <= write_value_i;
            REG_CHACTL: chctl_q <= write_value_i;
            REG_DLISTL: lst_q[7:0] <= write_value_i;
            REG_DLISTH: lst_q[15:8] <= write_value_i;
            REG_HSCROL: hsa_q <= write_value_i[3:0];
            REG_VSCROL: vsa_q <= write_value_i[3:0];
            REG_PMBASE: pmb_q <= write_value_i;
            REG_CHBASE: chb_q <= write_value_i;
            REG_WSYNC:  wsync_q <= 1'b1;
            REG_NMIEN:  nmien_q <= write_value_i;
            REG_NMIST:  nmist_q <= '0;
            default: ;
          endcase
        end
        OP_READ: begin
          {fa_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
          kind_q <= KIND_READ;
          if (reg_offset_i == REG_VCOUNT) rd_q <= vcount_q[8:1];
          else if (reg_offset_i == REG_NMIST) rd_q <= nmist_q;
          else rd_q <= 8'hFF;
        end
        OP_FRAME: begin
          ph_q <= PH_IDLE; pnmi_q <= '0; lp_q <= lst_q;
          mode_q <= '0; row_q <= '0; hgt_q <= '0; fin_q <= 1'b0;
        end
        OP_LINE: begin
          ph_q <= PH_IDLE;
          vcount_q <= line_number_i;
          pline_q <= line_number_i;
          pst_q <= '0;
          pnmi_q <= '0;
          if (line_number_i == VblL) begin
            nmist_q <= {2'b01, nmist_q[5:0]};
            if (nmien_q[6]) pnmi_q <= 2'd2;
          end
          if (need_new) begin
            pst_q <= 8'd1;
            if (!dma_q[5] || fin_q) begin
              mode_q <= '0; hgt_q <= 5'd1; row_q <= '0;
            end else begin
              guard_q <= '0; ph_q <= PH_INSN;
              kind_q <= KIND_FETCH; fa_q <= lp_q;
              {rd_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
            end
          end
        end
        OP_MEM: begin
          unique case (ph_q)
            PH_INSN: begin
              lp_q <= lp_q + 16'd1;
              instr_q <= mem_byte_i;
              dli_q <= mem_byte_i[7];
              if (mem_byte_i[3:0] == 4'd0) begin
                mode_q <= '0; row_q <= '0;
                hgt_q <= {2'b00, mem_byte_i[6:4]} + 5'd1;
              end else if (mem_byte_i[3:0] == 4'd1) begin
                ph_q <= PH_JLO; kind_q <= KIND_FETCH; fa_q <= lp_q + 16'd1;
                {rd_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
              end else if (mem_byte_i[6]) begin
                ph_q <= PH_LLO; kind_q <= KIND_FETCH; fa_q <= lp_q + 16'd1;
                {rd_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
              end else begin
                hson_q <= mem_byte_i[4]; vson_q <= mem_byte_i[5];
                mode_q <= mem_byte_i[3:0]; hgt_q <= blk_lines(mem_byte_i[3:0]);
                row_q <= '0;
              end
            end
            PH_JLO, PH_LLO: begin
              lp_q <= lp_q + 16'd1; lo_q <= mem_byte_i; ph_q <= ph_q + 3'd1;
              kind_q <= KIND_FETCH; fa_q <= lp_q + 16'd1;
              {rd_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
            end
            PH_JHI: begin
              lp_q <= target;
              if (instr_q[6]) begin
                lst_q <= target; fin_q <= 1'b1;
                mode_q <= '0; hgt_q <= 5'd1; row_q <= '0;
              end else begin
                guard_q <= guard_inc;
                if (guard_inc >= GuardL) begin
                  fin_q <= 1'b1; mode_q <= '0; hgt_q <= 5'd1; row_q <= '0;
                end else begin
                  ph_q <= PH_INSN; kind_q <= KIND_FETCH; fa_q <= target;
                  {rd_q, st_q, nr_q, lm_q, br_q, scr_q} <= '0;
                end
              end
            end
            PH_LHI: begin
              lp_q <= lp_q + 16'd1;
              scan_q <= target;
              hson_q <= instr_q[4]; vson_q <= instr_q[5];
              mode_q <= instr_q[3:0]; hgt_q <= blk_lines(instr_q[3:0]);
              row_q <= '0;
            end
            default: ;
          endcase
        end
        OP_FINISH: begin
          ph_q <= PH_IDLE;
          kind_q <= KIND_LINE; rd_q <= '0; fa_q <= '0;
          st_q <= (stolen_sum > CapL) ? CapL[6:0] : stolen_sum[6:0];
          lm_q <= mode_q; br_q <= row_q; scr_q <= scan_q;
          pnmi_q <= '0;
          nr_q <= pnmi_q | {1'b0, dli_hit && nmien_q[7]};
          if (dli_hit) nmist_q <= {2'b10, nmist_q[5:0]};
          if ((pline_q < VblL) && (hgt_q != 5'd0)) begin
            row_q <= row_inc;
            if ((row_inc >= hgt_q) && (mode_q >= 4'd2)) scan_q <= scan_q + bb;
          end
        end
        default: ;
      endcase
    end
  end

  assign result_kind_o    = kind_q;
  assign read_data_o      = rd_q;
  assign fetch_address_o  = fa_q;
  assign stolen_cycles_o  = st_q;
  assign nmi_raised_o     = nr_q;
  assign line_mode_o      = lm_q;
  assign block_row_o      = br_q;
  assign screen_address_o = scr_q;

  logic unused;
  assign unused = ^{chctl_q, pmb_q, chb_q, hsa_q, vsa_q, hson_q, vson_q, wsync_q};

endmodule
